/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files; swlw_back uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, off while reset is asserted.
`define SWLW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge.
`define SWLW_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SWLW_ASSERT(label, clk, rst_n, prop, msg)
`define SWLW_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/swlw_pkg.sv */
package swlw_pkg;

	// Configuration port
	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned TICK_W     = 10;

	localparam logic [1:0] REG_LONG      = 2'd0;
	localparam logic [1:0] REG_SHORT     = 2'd1;
	localparam logic [1:0] REG_STOP_HIGH = 2'd2;
	localparam logic [1:0] REG_STOP_LOW  = 2'd3;

	localparam logic [TICK_W-1:0] LONG_RST      = 10'd15;
	localparam logic [TICK_W-1:0] SHORT_RST     = 10'd5;
	localparam logic [TICK_W-1:0] STOP_HIGH_RST = 10'd5;
	localparam logic [TICK_W-1:0] STOP_LOW_RST  = 10'd30;

	// Frame layout
	localparam logic [2:0] FRAME_LAST = 3'd4;
	localparam logic [3:0] BIT_LAST   = 4'd10;

	// Timing registers as seen by the back end
	typedef struct packed {
		logic [TICK_W-1:0] long_ticks;
		logic [TICK_W-1:0] short_ticks;
		logic [TICK_W-1:0] stop_high_ticks;
		logic [TICK_W-1:0] stop_low_ticks;
	} cfg_t;

	// Classified command word
	typedef struct packed {
		logic       start;
		logic [1:0] pattern;
		logic       channel;
	} cmd_t;

	// Data byte of pattern row and frame (register address)
	function automatic logic [7:0] pattern_byte(input logic [1:0] row, input logic [2:0] frame);
		logic [7:0] b;
		b = 8'h00;
		case (frame)
			3'd1, 3'd3: begin
				case (row)
					2'd2:    b = 8'hF0;
					2'd3:    b = 8'h0F;
					default: b = 8'h31;
				endcase
			end
			3'd4: b = (row == 2'd1) ? 8'h06 : 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* rtl/core/swlw_cmd_if.sv */
interface swlw_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [1:0] pattern;
	logic       channel;

	modport source(output valid, output opcode, output pattern, output channel, input ready);
	modport sink(input valid, input opcode, input pattern, input channel, output ready);
endinterface

/* rtl/core/swlw_res_if.sv */
interface swlw_res_if;
	logic valid;
	logic ready;
	logic red_line;
	logic blue_line;
	logic busy_res;
	logic rejected;

	modport source(output valid, output red_line, output blue_line, output busy_res,
		output rejected, input ready);
	modport sink(input valid, input red_line, input blue_line, input busy_res,
		input rejected, output ready);
endinterface

/* rtl/core/swlw_front.sv */
module swlw_front (
	input  logic                clk,
	input  logic                arst_n,
	swlw_cmd_if.sink            cmd,
	output logic                vld,
	output swlw_pkg::cmd_t      word,
	input  logic                q_ready
);

	logic           vld_s1;
	swlw_pkg::cmd_t word_s1;

	// Take a new word when the stage is empty or drains this cycle
	assign cmd.ready = !vld_s1 || q_ready;

	// Classify and hold the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			word_s1.start   <= cmd.opcode;
			word_s1.pattern <= cmd.pattern;
			word_s1.channel <= cmd.channel;
		end
	end

	assign vld  = vld_s1;
	assign word = word_s1;

endmodule

/* rtl/core/swlw_queue.sv */
module swlw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swlw_pkg::cmd_t push_word,
	output logic           ready,
	output logic           vld,
	output swlw_pkg::cmd_t head,
	input  logic           pop
);

	swlw_pkg::cmd_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign ready   = (cnt_q != 2'd2);
	assign vld     = (cnt_q != 2'd0);
	assign head    = mem_q[rd_q];
	assign do_push = push && ready;
	assign do_pop  = pop && vld;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_word;
	end

endmodule

/* rtl/core/swlw_back.sv */
`include "assert_macros.svh"

module swlw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  swlw_pkg::cfg_t cfg,
	input  logic           q_vld,
	input  swlw_pkg::cmd_t q_word,
	output logic           pop,
	swlw_res_if.source     res
);

	typedef enum logic [1:0] {
		PH_BIT_HIGH  = 2'd0,
		PH_BIT_LOW   = 2'd1,
		PH_STOP_HIGH = 2'd2,
		PH_STOP_LOW  = 2'd3
	} phase_t;

	// Sequencer state
	logic                        active_q;
	logic                        line_q;
	logic [1:0]                  row_q;
	logic [2:0]                  frame_q;
	logic [10:0]                 shift_q;
	logic [3:0]                  bit_q;
	phase_t                      phase_q;
	logic [swlw_pkg::TICK_W-1:0] count_q;

	// Output register
	logic res_vld_q;
	logic red_q;
	logic blue_q;
	logic busy_q;
	logic rej_q;

	// Next values
	logic                        active_d;
	logic                        line_d;
	logic [1:0]                  row_d;
	logic [2:0]                  frame_d;
	logic [10:0]                 shift_d;
	logic [3:0]                  bit_d;
	phase_t                      phase_d;
	logic [swlw_pkg::TICK_W-1:0] count_d;
	logic                        rej_d;
	logic                        level_d;
	logic [swlw_pkg::TICK_W-1:0] len_raw;
	logic [swlw_pkg::TICK_W-1:0] len;
	logic [swlw_pkg::TICK_W:0]   count_inc;
	logic [2:0]                  frame_nx;

	assign pop = q_vld && (!res_vld_q || res.ready);

	// Length of the current phase, zero acting as one
	always_comb begin
		unique case (phase_q)
			PH_BIT_HIGH:  len_raw = shift_q[0] ? cfg.long_ticks : cfg.short_ticks;
			PH_BIT_LOW:   len_raw = shift_q[0] ? cfg.short_ticks : cfg.long_ticks;
			PH_STOP_HIGH: len_raw = cfg.stop_high_ticks;
			default:      len_raw = cfg.stop_low_ticks;
		endcase
		len = (len_raw == '0) ? swlw_pkg::TICK_W'(1) : len_raw;
	end

	assign count_inc = {1'b0, count_q} + (swlw_pkg::TICK_W+1)'(1);
	assign frame_nx  = frame_q + 3'd1;

	// Step the sequencer for one word
	always_comb begin
		active_d = active_q;
		line_d   = line_q;
		row_d    = row_q;
		frame_d  = frame_q;
		shift_d  = shift_q;
		bit_d    = bit_q;
		phase_d  = phase_q;
		count_d  = count_q;
		rej_d    = 1'b0;
		if (q_word.start) begin
			if (active_q) begin
				rej_d = 1'b1;
			end else begin
				active_d = 1'b1;
				row_d    = q_word.pattern;
				line_d   = q_word.channel;
				frame_d  = 3'd0;
				shift_d  = {swlw_pkg::pattern_byte(q_word.pattern, 3'd0), 3'd0};
				bit_d    = 4'd0;
				phase_d  = PH_BIT_HIGH;
				count_d  = '0;
			end
		end else if (active_q) begin
			if (count_inc < {1'b0, len}) begin
				count_d = count_inc[swlw_pkg::TICK_W-1:0];
			end else begin
				count_d = '0;
				unique case (phase_q)
					PH_BIT_HIGH: phase_d = PH_BIT_LOW;
					PH_BIT_LOW: begin
						if (bit_q < swlw_pkg::BIT_LAST) begin
							bit_d   = bit_q + 4'd1;
							shift_d = {1'b0, shift_q[10:1]};
							phase_d = PH_BIT_HIGH;
						end else begin
							phase_d = PH_STOP_HIGH;
						end
					end
					PH_STOP_HIGH: phase_d = PH_STOP_LOW;
					default: begin
						if (frame_q < swlw_pkg::FRAME_LAST) begin
							frame_d = frame_nx;
							shift_d = {swlw_pkg::pattern_byte(row_q, frame_nx), frame_nx};
							bit_d   = 4'd0;
							phase_d = PH_BIT_HIGH;
						end else begin
							active_d = 1'b0;
							frame_d  = 3'd0;
							shift_d  = '0;
							bit_d    = 4'd0;
							phase_d  = PH_BIT_HIGH;
						end
					end
				endcase
			end
		end
		level_d = active_d && (phase_d == PH_BIT_HIGH || phase_d == PH_STOP_HIGH);
	end

	// Hold sequencer state and the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			line_q    <= 1'b0;
			row_q     <= 2'd0;
			frame_q   <= 3'd0;
			shift_q   <= '0;
			bit_q     <= 4'd0;
			phase_q   <= PH_BIT_HIGH;
			count_q   <= '0;
			res_vld_q <= 1'b0;
			red_q     <= 1'b0;
			blue_q    <= 1'b0;
			busy_q    <= 1'b0;
			rej_q     <= 1'b0;
		end else begin
			if (pop) begin
				active_q  <= active_d;
				line_q    <= line_d;
				row_q     <= row_d;
				frame_q   <= frame_d;
				shift_q   <= shift_d;
				bit_q     <= bit_d;
				phase_q   <= phase_d;
				count_q   <= count_d;
				res_vld_q <= 1'b1;
				red_q     <= level_d && !line_d;
				blue_q    <= level_d && line_d;
				busy_q    <= active_d;
				rej_q     <= rej_d;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign res.valid     = res_vld_q;
	assign res.red_line  = red_q;
	assign res.blue_line = blue_q;
	assign res.busy_res  = busy_q;
	assign res.rejected  = rej_q;

	`SWLW_ASSERT(a_rej_busy, clk, arst_n, res_vld_q && rej_q |-> busy_q, "rejected while idle")
	`SWLW_NEVER(a_both_lines, clk, arst_n, red_q && blue_q, "both lines driven high")
	`SWLW_ASSERT(a_idle_low, clk, arst_n, !busy_q |-> !red_q && !blue_q, "line high while idle")
	`SWLW_ASSERT(a_frame_range, clk, arst_n, frame_q <= swlw_pkg::FRAME_LAST, "frame past last")

endmodule

/* rtl/core/single_wire_led_register_writer.sv */
// A command word passes the front stage, then a two-word queue, then the output
// register. Throughput: one word per cycle while the output is not stalled;
// these stages let input and output stall independently.
// Reset (arst_n, asynchronous, active low): sequencer idle, both lines low,
// timing registers back to 15, 5, 5 and 30 ticks.
module single_wire_led_register_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	swlw_cmd_if.sink                          cmd,
	swlw_res_if.source                        res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [swlw_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	swlw_pkg::cfg_t cfg_q;
	logic           f_vld;
	swlw_pkg::cmd_t f_word;
	logic           q_ready;
	logic           q_vld;
	swlw_pkg::cmd_t q_head;
	logic           q_pop;
	logic [1:0]     reg_idx;
	logic [swlw_pkg::TICK_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// Write timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks      <= swlw_pkg::LONG_RST;
			cfg_q.short_ticks     <= swlw_pkg::SHORT_RST;
			cfg_q.stop_high_ticks <= swlw_pkg::STOP_HIGH_RST;
			cfg_q.stop_low_ticks  <= swlw_pkg::STOP_LOW_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				swlw_pkg::REG_LONG:      cfg_q.long_ticks      <= pwdata[9:0];
				swlw_pkg::REG_SHORT:     cfg_q.short_ticks     <= pwdata[9:0];
				swlw_pkg::REG_STOP_HIGH: cfg_q.stop_high_ticks <= pwdata[9:0];
				default:                 cfg_q.stop_low_ticks  <= pwdata[9:0];
			endcase
		end
	end

	// Read back timing registers
	always_comb begin
		unique case (reg_idx)
			swlw_pkg::REG_LONG:      rd_val = cfg_q.long_ticks;
			swlw_pkg::REG_SHORT:     rd_val = cfg_q.short_ticks;
			swlw_pkg::REG_STOP_HIGH: rd_val = cfg_q.stop_high_ticks;
			default:                 rd_val = cfg_q.stop_low_ticks;
		endcase
		prdata = {22'd0, rd_val};
	end

	swlw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.vld     (f_vld),
		.word    (f_word),
		.q_ready (q_ready)
	);

	swlw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_vld),
		.push_word (f_word),
		.ready     (q_ready),
		.vld       (q_vld),
		.head      (q_head),
		.pop       (q_pop)
	);

	swlw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_vld  (q_vld),
		.q_word (q_head),
		.pop    (q_pop),
		.res    (res)
	);

endmodule
